@@ design/lsm_pkg.sv @@
// Shared types, constants and helpers for the line substring matcher.
// No dependencies; every other design file imports this package.
`default_nettype none

package lsm_pkg;

    localparam int unsigned PATTERN_MAX_DEF = 16;  // default match vector width
    localparam int unsigned PAT_BYTES       = 16;  // pattern bytes held in registers
    localparam int unsigned CFG_DATA_W      = 64;
    localparam int unsigned CFG_IDX_W       = 2;
    localparam int unsigned CFG_LEN_W       = 5;
    localparam int unsigned LEN_EXT_W       = 7;   // holds any length up to 64
    localparam int unsigned CNT_W           = 32;
    localparam logic [7:0]  NEWLINE_BYTE    = 8'd10;
    localparam logic [CNT_W-1:0] CNT_MAX    = '1;

    typedef enum logic [1:0] {
        REQ_BYTE  = 2'd0,
        REQ_EOF   = 2'd1,
        REQ_START = 2'd2
    } lsm_req_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_PAT_LOW  = 2'd0,
        CFG_PAT_HIGH = 2'd1,
        CFG_PAT_LEN  = 2'd2
    } lsm_cfg_t;

    // Decoded operation of one accepted transaction; all zero when idle.
    typedef struct packed {
        logic content;       // byte other than newline
        logic newline;       // newline byte closing a line
        logic file_end;      // end-of-file request
        logic start_search;  // start-search request
    } lsm_op_t;

    function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
        sat_inc = (v == CNT_MAX) ? v : v + CNT_W'(1);
    endfunction

endpackage

`default_nettype wire

@@ design/lsm_shift_and.sv @@
// Shift-and match vector and per-line hit flag.
// Depends on lsm_pkg.
`default_nettype none

module lsm_shift_and #(
    parameter int unsigned PATTERN_MAX = 16
) (
    input  wire                               aclk,
    input  wire                               aresetn,
    input  lsm_pkg::lsm_op_t                  op,
    input  wire  [7:0]                        data_byte,
    input  wire  [lsm_pkg::CFG_DATA_W-1:0]    pattern_low,
    input  wire  [lsm_pkg::CFG_DATA_W-1:0]    pattern_high,
    input  wire  [lsm_pkg::CFG_LEN_W-1:0]     pattern_length,
    output logic                              line_matched
);
    import lsm_pkg::*;

    localparam logic [LEN_EXT_W-1:0] PMAX_EXT = LEN_EXT_W'(PATTERN_MAX);

    logic [PATTERN_MAX-1:0]      partial_reg, partial_next;
    logic                        hit_reg, hit_next;
    logic [PATTERN_MAX-1:0]      eq_vec;
    logic [PATTERN_MAX-1:0]      top_sel;
    logic [LEN_EXT_W-1:0]        len_ext, eff_len;
    logic [2*CFG_DATA_W-1:0]     pattern_all;

    assign pattern_all = {pattern_high, pattern_low};
    assign len_ext     = LEN_EXT_W'(pattern_length);
    // Clamp the length to the width of the match vector
    assign eff_len     = (len_ext > PMAX_EXT) ? PMAX_EXT : len_ext;

    for (genvar k = 0; k < PATTERN_MAX; k++) begin : g_bit
        logic [7:0] pat_byte;
        if (k < PAT_BYTES) begin : g_held
            assign pat_byte = pattern_all[k*8 +: 8];
        end else begin : g_zero
            assign pat_byte = 8'd0;
        end
        assign eq_vec[k]  = (pat_byte == data_byte) && (LEN_EXT_W'(k) < eff_len);
        assign top_sel[k] = (eff_len == LEN_EXT_W'(k + 1));
    end

    always_comb begin
        partial_next = ((partial_reg << 1) | PATTERN_MAX'(1)) & eq_vec;
        hit_next     = hit_reg | (|(partial_next & top_sel));
    end

    assign line_matched = hit_reg || (eff_len == '0);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            partial_reg <= '0;
            hit_reg     <= 1'b0;
        end else if (op.newline || op.file_end) begin
            partial_reg <= '0;
            hit_reg     <= 1'b0;
        end else if (op.content) begin
            partial_reg <= partial_next;
            hit_reg     <= hit_next;
        end
    end

`ifndef SYNTHESIS
    a_clear_at_line_end: assert property (@(posedge aclk) disable iff (!aresetn)
        (op.newline || op.file_end) |=> (!hit_reg && partial_reg == '0))
        else $error("match state not cleared at line end");

    a_hit_from_byte: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(hit_reg) |-> $past(op.content))
        else $error("hit flag set without a content byte");

    a_hit_sticky_in_line: assert property (@(posedge aclk) disable iff (!aresetn)
        (hit_reg && !op.newline && !op.file_end) |=> hit_reg)
        else $error("hit flag lost inside a line");
`endif

endmodule

`default_nettype wire

@@ design/lsm_line_track.sv @@
// Line number, byte position, line start and sticky match flag.
// Depends on lsm_pkg.
`default_nettype none

module lsm_line_track (
    input  wire                           aclk,
    input  wire                           aresetn,
    input  lsm_pkg::lsm_op_t              op,
    input  wire                           line_matched,
    output logic [lsm_pkg::CNT_W-1:0]     line_number,
    output logic [lsm_pkg::CNT_W-1:0]     line_start,
    output logic [lsm_pkg::CNT_W-1:0]     line_length,
    output logic                          any_match
);
    import lsm_pkg::*;

    logic [CNT_W-1:0] line_number_reg;
    logic [CNT_W-1:0] byte_pos_reg;
    logic [CNT_W-1:0] line_start_reg;
    logic             sticky_reg;
    logic [CNT_W-1:0] byte_pos_inc;

    assign byte_pos_inc = sat_inc(byte_pos_reg);

    assign line_number = line_number_reg;
    assign line_start  = line_start_reg;
    assign line_length = byte_pos_reg - line_start_reg;
    // Flag as seen after this line closes
    assign any_match   = sticky_reg | (line_matched & (op.newline | op.file_end));

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            line_number_reg <= CNT_W'(1);
            byte_pos_reg    <= '0;
            line_start_reg  <= '0;
            sticky_reg      <= 1'b0;
        end else begin
            if (op.content) begin
                byte_pos_reg <= byte_pos_inc;
            end
            if (op.newline) begin
                line_number_reg <= sat_inc(line_number_reg);
                byte_pos_reg    <= byte_pos_inc;
                line_start_reg  <= byte_pos_inc;
            end
            if (op.file_end) begin
                line_number_reg <= CNT_W'(1);
                byte_pos_reg    <= '0;
                line_start_reg  <= '0;
            end
            if (op.newline || op.file_end) begin
                sticky_reg <= any_match;
            end
            if (op.start_search) begin
                sticky_reg <= 1'b0;
            end
        end
    end

`ifndef SYNTHESIS
    a_start_not_past_pos: assert property (@(posedge aclk) disable iff (!aresetn)
        line_start_reg <= byte_pos_reg)
        else $error("line start beyond byte position");

    a_file_restart: assert property (@(posedge aclk) disable iff (!aresetn)
        op.file_end |=> (line_number_reg == CNT_W'(1) && byte_pos_reg == '0))
        else $error("per-file counters not restarted");

    a_sticky_cleared: assert property (@(posedge aclk) disable iff (!aresetn)
        op.start_search |=> !sticky_reg)
        else $error("sticky flag survives start search");
`endif

endmodule

`default_nettype wire

@@ design/line_substring_matcher.sv @@
// Top level of the line substring matcher: config registers, request decode,
// result register. Depends on lsm_pkg, lsm_shift_and and lsm_line_track.
// Usage:
//   Input channel s_*: one transaction per request. s_tuser[1:0] is the
//   request kind (content byte, end of file, start search), s_tdata[7:0]
//   the content byte. Content is split into lines at newline.
//   Result channel m_*: one transaction for every newline that closes a
//   matching line and for every end-of-file request (m_tlast high on the
//   latter). Other requests produce nothing.
//   Configuration: write pattern bytes and pattern length on cfg_* only
//   while no request is in flight; a length of 0 matches every line.
// Timing:
//   A result appears on m_* in the cycle after its request is accepted.
//   Throughput is one request per clock, held only by the single result
//   register.
//   While the receiver stalls a waiting result, s_tready drops and the
//   result holds; requests that cause no result still flow when the
//   register is empty.
// Reset (aresetn low, synchronous): clears pattern registers, line counters,
//   match state, the sticky flag and the result valid.
`default_nettype none

module line_substring_matcher #(
    parameter int unsigned PATTERN_MAX = lsm_pkg::PATTERN_MAX_DEF
) (
    input  wire                              aclk,
    input  wire                              aresetn,
    // input channel
    input  wire                              s_tvalid,
    output logic                             s_tready,
    input  wire  [7:0]                       s_tdata,   // [7:0] data_byte
    input  wire  [1:0]                       s_tuser,   // [1:0] req_type
    // result channel
    output logic                             m_tvalid,
    input  wire                              m_tready,
    // [31:0] line_number, [63:32] line_start, [95:64] line_length,
    // [96] line_matched, [97] any_match, [103:98] zero
    output logic [103:0]                     m_tdata,
    output logic                             m_tlast,   // file_end
    // configuration write port
    input  wire                              cfg_we,
    input  wire  [lsm_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  wire  [lsm_pkg::CFG_DATA_W-1:0]   cfg_data
);
    import lsm_pkg::*;

    logic [CFG_DATA_W-1:0] pat_low_reg, pat_high_reg;
    logic [CFG_LEN_W-1:0]  pat_len_reg;

    logic                  s_accept;
    lsm_op_t               op;
    logic                  line_matched;
    logic [CNT_W-1:0]      line_number, line_start, line_length;
    logic                  any_match;
    logic                  emit;

    logic                  m_valid_reg;
    logic [103:0]          m_data_reg;
    logic                  m_last_reg;

    // Configuration registers: written directly, no read-back
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pat_low_reg  <= '0;
            pat_high_reg <= '0;
            pat_len_reg  <= '0;
        end else if (cfg_we) begin
            case (cfg_index)
                CFG_PAT_LOW:  pat_low_reg  <= cfg_data;
                CFG_PAT_HIGH: pat_high_reg <= cfg_data;
                CFG_PAT_LEN:  pat_len_reg  <= cfg_data[CFG_LEN_W-1:0];
                default:      ;  // unused index: drop the write
            endcase
        end
    end

    // Accept whenever the result register is empty or being drained
    assign s_tready = !m_valid_reg || m_tready;
    assign s_accept = s_tvalid && s_tready;

    // Decode the accepted transaction; request code 3 decodes to nothing
    always_comb begin
        op              = '0;
        op.content      = s_accept && (s_tuser == REQ_BYTE) && (s_tdata != NEWLINE_BYTE);
        op.newline      = s_accept && (s_tuser == REQ_BYTE) && (s_tdata == NEWLINE_BYTE);
        op.file_end     = s_accept && (s_tuser == REQ_EOF);
        op.start_search = s_accept && (s_tuser == REQ_START);
    end

    lsm_shift_and #(
        .PATTERN_MAX (PATTERN_MAX)
    ) u_shift_and (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .op             (op),
        .data_byte      (s_tdata),
        .pattern_low    (pat_low_reg),
        .pattern_high   (pat_high_reg),
        .pattern_length (pat_len_reg),
        .line_matched   (line_matched)
    );

    lsm_line_track u_line_track (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .op           (op),
        .line_matched (line_matched),
        .line_number  (line_number),
        .line_start   (line_start),
        .line_length  (line_length),
        .any_match    (any_match)
    );

    // A matching newline or any end-of-file produces a result
    assign emit = (op.newline && line_matched) || op.file_end;

    // Result register: load on a producing transaction, clear when taken
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (emit) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    // Payload needs no reset; advance only on a new result
    always_ff @(posedge aclk) begin
        if (emit) begin
            m_data_reg <= {6'd0, any_match, line_matched,
                           line_length, line_start, line_number};
            m_last_reg <= op.file_end;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tlast  = m_last_reg;

`ifndef SYNTHESIS
    a_eof_gives_result: assert property (@(posedge aclk) disable iff (!aresetn)
        op.file_end |=> (m_valid_reg && m_last_reg))
        else $error("end of file without a final result");

    a_start_no_result: assert property (@(posedge aclk) disable iff (!aresetn)
        op.start_search |=> !m_valid_reg)
        else $error("start search produced a result");

    a_line_result_matched: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && !m_last_reg) |-> m_data_reg[96])
        else $error("unmatched line reported");

    a_match_sets_any: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && m_data_reg[96]) |-> m_data_reg[97])
        else $error("matched line without sticky flag");
`endif

endmodule

`default_nettype wire
